/* sv/bowp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bowp_pkg
// Shared constants and register codes of the window placement check unit.
// ---------------------------------------------------------------------------
package bowp_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Queue depths: input queue between front and back, result queue toward the consumer
    localparam int IN_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    // Register reset values
    localparam int WINDOW_X_RST      = 0;
    localparam int WINDOW_Y_RST      = 0;
    localparam int WINDOW_WIDTH_RST  = 640;
    localparam int WINDOW_HEIGHT_RST = 480;
    localparam int MIN_VISIBLE_RST   = 100;
    localparam int TOP_TOL_RST       = 40;
    localparam int MIN_TITLE_RST     = 30;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_X      = 3'd0,
        REG_WINDOW_Y      = 3'd1,
        REG_WINDOW_WIDTH  = 3'd2,
        REG_WINDOW_HEIGHT = 3'd3,
        REG_MIN_VISIBLE   = 3'd4,
        REG_TOP_TOL       = 3'd5,
        REG_MIN_TITLE     = 3'd6
    } cfg_reg_t;

endpackage

/* sv/bowp_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bowp_queue
// Small first-in first-out queue in flops, head word shown combinationally.
// ---------------------------------------------------------------------------
module bowp_queue
    import bowp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4     // power of two, at least 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/bowp_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bowp_front
// Intersects an incoming work area with the window and classifies it.
// ---------------------------------------------------------------------------
module bowp_front
    import bowp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           present,
    input  logic signed [COORD_BITS-1:0]   area_x,
    input  logic signed [COORD_BITS-1:0]   area_y,
    input  logic        [COORD_BITS-2:0]   area_width,
    input  logic        [COORD_BITS-2:0]   area_height,
    input  logic                           last,
    input  logic signed [COORD_BITS-1:0]   wx,
    input  logic signed [COORD_BITS-1:0]   wy,
    input  logic        [COORD_BITS-2:0]   ww,
    input  logic        [COORD_BITS-2:0]   wh,
    // word = {hit, last, ow, oh, ay, aw, ah}
    output logic [5*COORD_BITS-3:0]        word
);

    localparam int SW = COORD_BITS - 1;
    localparam int EW = COORD_BITS + 2;

    logic signed [EW-1:0] wx_e, wy_e, ax_e, ay_e;
    logic signed [EW-1:0] w_right, w_bot, a_right, a_bot;
    logic signed [EW-1:0] left, top, right, bot;
    logic signed [EW-1:0] ow, oh;
    logic                 hit;

    always_comb
    begin
        wx_e    = EW'(wx);
        wy_e    = EW'(wy);
        ax_e    = EW'(area_x);
        ay_e    = EW'(area_y);
        w_right = wx_e + $signed({3'b000, ww});
        w_bot   = wy_e + $signed({3'b000, wh});
        a_right = ax_e + $signed({3'b000, area_width});
        a_bot   = ay_e + $signed({3'b000, area_height});
        left    = (wx_e > ax_e) ? wx_e : ax_e;
        top     = (wy_e > ay_e) ? wy_e : ay_e;
        right   = (w_right < a_right) ? w_right : a_right;
        bot     = (w_bot < a_bot) ? w_bot : a_bot;
        ow      = right - left;
        oh      = bot - top;
        // positive overlap never exceeds the narrower width, so SW bits hold it
        hit     = present && (ow > 0) && (oh > 0);
        word    = {hit, last, ow[SW-1:0], oh[SW-1:0], area_y, area_width, area_height};
    end

endmodule

/* sv/bowp_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bowp_back
// Overlap area multiply, best-area tracking and end-of-list verdict.
// ---------------------------------------------------------------------------
module bowp_back
    import bowp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [5*COORD_BITS-3:0]        in_word,
    input  logic                           in_empty,
    output logic                           in_pop,
    input  logic signed [COORD_BITS-1:0]   wy,
    input  logic        [COORD_BITS-2:0]   ww,
    input  logic        [COORD_BITS-2:0]   wh,
    input  logic        [COORD_BITS-2:0]   mv,
    input  logic        [COORD_BITS-2:0]   tt,
    input  logic        [COORD_BITS-2:0]   mtb,
    output logic                           out_push,
    output logic [2*COORD_BITS-2:0]        out_word,
    input  logic                           out_full
);

    localparam int SW = COORD_BITS - 1;
    localparam int PW = 2 * SW;
    localparam int EW = COORD_BITS + 2;

    // incoming word fields
    logic                  i_hit, i_last;
    logic [SW-1:0]         i_ow, i_oh, i_aw, i_ah;
    logic [COORD_BITS-1:0] i_ay;

    // multiply stage
    logic                  m_valid_reg, m_valid_next;
    logic                  m_hit_reg, m_last_reg;
    logic [SW-1:0]         m_ow_reg, m_oh_reg, m_aw_reg, m_ah_reg;
    logic [COORD_BITS-1:0] m_ay_reg;
    logic [PW-1:0]         m_area_reg;

    // running best
    logic                  found_reg, found_next;
    logic [PW-1:0]         best_area_reg, best_area_next;
    logic [COORD_BITS-1:0] best_ay_reg, best_ay_next;
    logic [SW-1:0]         best_aw_reg, best_aw_next;
    logic [SW-1:0]         best_ah_reg, best_ah_next;
    logic [SW-1:0]         best_ow_reg, best_ow_next;
    logic [SW-1:0]         best_oh_reg, best_oh_next;

    // candidate after this word
    logic                  c_found;
    logic [PW-1:0]         c_area;
    logic [COORD_BITS-1:0] c_ay;
    logic [SW-1:0]         c_aw, c_ah, c_ow, c_oh;
    logic                  upd, adv, take;

    // final stage snapshot
    logic                  f_valid_reg, f_valid_next;
    logic                  f_found_reg;
    logic [COORD_BITS-1:0] f_ay_reg;
    logic [SW-1:0]         f_aw_reg, f_ah_reg, f_ow_reg, f_oh_reg;

    logic signed [EW-1:0]  wy_e, ay_e, lo_lim, hi_lim;
    logic                  ok;
    logic [SW-1:0]         cw, ch;

    assign {i_hit, i_last, i_ow, i_oh, i_ay, i_aw, i_ah} = in_word;

    // one stall for the whole back pipe: the verdict cannot leave
    assign adv      = !(f_valid_reg && out_full);
    assign in_pop   = adv && !in_empty;
    assign take     = adv && m_valid_reg;
    assign out_push = adv && f_valid_reg;

    always_comb
    begin
        m_valid_next = adv ? !in_empty : m_valid_reg;
        f_valid_next = adv ? (m_valid_reg && m_last_reg) : f_valid_reg;

        // strictly larger wins, so the first area keeps a tie
        upd     = m_hit_reg && (!found_reg || (m_area_reg > best_area_reg));
        c_found = found_reg || upd;
        c_area  = upd ? m_area_reg : best_area_reg;
        c_ay    = upd ? m_ay_reg   : best_ay_reg;
        c_aw    = upd ? m_aw_reg   : best_aw_reg;
        c_ah    = upd ? m_ah_reg   : best_ah_reg;
        c_ow    = upd ? m_ow_reg   : best_ow_reg;
        c_oh    = upd ? m_oh_reg   : best_oh_reg;

        found_next     = found_reg;
        best_area_next = best_area_reg;
        best_ay_next   = best_ay_reg;
        best_aw_next   = best_aw_reg;
        best_ah_next   = best_ah_reg;
        best_ow_next   = best_ow_reg;
        best_oh_next   = best_oh_reg;
        if (take)
        begin
            if (m_last_reg)
            begin
                found_next     = 1'b0;
                best_area_next = '0;
                best_ay_next   = '0;
                best_aw_next   = '0;
                best_ah_next   = '0;
                best_ow_next   = '0;
                best_oh_next   = '0;
            end
            else
            begin
                found_next     = c_found;
                best_area_next = c_area;
                best_ay_next   = c_ay;
                best_aw_next   = c_aw;
                best_ah_next   = c_ah;
                best_ow_next   = c_ow;
                best_oh_next   = c_oh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            best_area_reg <= '0;
            best_ay_reg   <= '0;
            best_aw_reg   <= '0;
            best_ah_reg   <= '0;
            best_ow_reg   <= '0;
            best_oh_reg   <= '0;
        end
        else
        begin
            m_valid_reg   <= m_valid_next;
            f_valid_reg   <= f_valid_next;
            found_reg     <= found_next;
            best_area_reg <= best_area_next;
            best_ay_reg   <= best_ay_next;
            best_aw_reg   <= best_aw_next;
            best_ah_reg   <= best_ah_next;
            best_ow_reg   <= best_ow_next;
            best_oh_reg   <= best_oh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            m_hit_reg  <= i_hit;
            m_last_reg <= i_last;
            m_ow_reg   <= i_ow;
            m_oh_reg   <= i_oh;
            m_ay_reg   <= i_ay;
            m_aw_reg   <= i_aw;
            m_ah_reg   <= i_ah;
            m_area_reg <= PW'(i_ow) * PW'(i_oh);
        end
        if (take && m_last_reg)
        begin
            f_found_reg <= c_found;
            f_ay_reg    <= c_ay;
            f_aw_reg    <= c_aw;
            f_ah_reg    <= c_ah;
            f_ow_reg    <= c_ow;
            f_oh_reg    <= c_oh;
        end
    end

    // verdict on the chosen area
    always_comb
    begin
        wy_e   = EW'(wy);
        ay_e   = EW'($signed(f_ay_reg));
        lo_lim = ay_e - $signed({3'b000, tt});
        hi_lim = ay_e + $signed({3'b000, f_ah_reg}) - $signed({3'b000, mtb});
        ok     = f_found_reg && (f_ow_reg >= mv) && (f_oh_reg >= mv)
                 && !(wy_e < lo_lim) && !(wy_e > hi_lim);
        cw     = (ww < f_aw_reg) ? ww : f_aw_reg;
        ch     = (wh < f_ah_reg) ? wh : f_ah_reg;
        out_word = ok ? {1'b1, cw, ch} : '0;
    end

endmodule

/* sv/best_overlap_window_placement_check_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// best_overlap_window_placement_check_unit
// Checks a saved window rectangle against a streamed list of work areas.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                Word
//  -------   ----------------------   ---------------------------------------
//  input     push / full              present, area_x/y, area_width/height,
//                                     last
//  result    pop / empty              accepted, clamped_width, clamped_height
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data (ready always high)
//
//  One work area is taken every cycle while full is low. A word passes the front
//  (intersect and classify) in its accept cycle, then two back stages: the
//  overlap multiply and the best-area update. A result passes the multiply and
//  snapshot registers to the result queue; the best-area loop sets the
//  one-word-per-cycle rate. The back stalls only while its verdict finds the
//  result queue full; the input queue absorbs the words behind it. Reset empties
//  both queues, clears the running best and loads the register defaults.
// ---------------------------------------------------------------------------
module best_overlap_window_placement_check_unit
    import bowp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // work area input
    input  logic                          push,
    output logic                          full,
    input  logic                          present,
    input  logic signed [COORD_BITS-1:0]  area_x,
    input  logic signed [COORD_BITS-1:0]  area_y,
    input  logic        [COORD_BITS-2:0]  area_width,
    input  logic        [COORD_BITS-2:0]  area_height,
    input  logic                          last,
    // verdict output
    output logic                          empty,
    input  logic                          pop,
    output logic                          accepted,
    output logic        [COORD_BITS-2:0]  clamped_width,
    output logic        [COORD_BITS-2:0]  clamped_height,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_data
);

    localparam int SW = COORD_BITS - 1;
    localparam int QW = 5 * COORD_BITS - 2;   // front word width
    localparam int RW = 2 * COORD_BITS - 1;   // result word width

    // configuration registers
    logic signed [COORD_BITS-1:0] window_x_reg, window_y_reg;
    logic [SW-1:0] window_width_reg, window_height_reg;
    logic [SW-1:0] min_visible_reg, top_tol_reg, min_title_reg;

    logic [QW-1:0] front_word, q_word;
    logic          q_empty, q_pop;
    logic [RW-1:0] res_word_in, res_word_out;
    logic          res_push, res_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_x_reg      <= COORD_BITS'(WINDOW_X_RST);
            window_y_reg      <= COORD_BITS'(WINDOW_Y_RST);
            window_width_reg  <= SW'(WINDOW_WIDTH_RST);
            window_height_reg <= SW'(WINDOW_HEIGHT_RST);
            min_visible_reg   <= SW'(MIN_VISIBLE_RST);
            top_tol_reg       <= SW'(TOP_TOL_RST);
            min_title_reg     <= SW'(MIN_TITLE_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_X:      window_x_reg      <= cfg_data;
                REG_WINDOW_Y:      window_y_reg      <= cfg_data;
                REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[SW-1:0];
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_data[SW-1:0];
                REG_MIN_VISIBLE:   min_visible_reg   <= cfg_data[SW-1:0];
                REG_TOP_TOL:       top_tol_reg       <= cfg_data[SW-1:0];
                REG_MIN_TITLE:     min_title_reg     <= cfg_data[SW-1:0];
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // front: intersect with the window as the word arrives
    bowp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .present     (present),
        .area_x      (area_x),
        .area_y      (area_y),
        .area_width  (area_width),
        .area_height (area_height),
        .last        (last),
        .wx          (window_x_reg),
        .wy          (window_y_reg),
        .ww          (window_width_reg),
        .wh          (window_height_reg),
        .word        (front_word)
    );

    // decouples input acceptance from the back pipe
    bowp_queue #(.WIDTH(QW), .DEPTH(IN_QUEUE_DEPTH)) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_word),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_word),
        .empty (q_empty)
    );

    // back: multiply, keep best, judge at end of list
    bowp_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (q_word),
        .in_empty (q_empty),
        .in_pop   (q_pop),
        .wy       (window_y_reg),
        .ww       (window_width_reg),
        .wh       (window_height_reg),
        .mv       (min_visible_reg),
        .tt       (top_tol_reg),
        .mtb      (min_title_reg),
        .out_push (res_push),
        .out_word (res_word_in),
        .out_full (res_full)
    );

    // result queue toward the consumer
    bowp_queue #(.WIDTH(RW), .DEPTH(OUT_QUEUE_DEPTH)) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_word_out),
        .empty (empty)
    );

    assign {accepted, clamped_width, clamped_height} = res_word_out;

endmodule
